### sv/hsf_pkg.sv
// Shared types, constants and helper functions for the hash sentence framer.
// No dependencies; imported by hsf_frame, hash_sentence_framer and the testbench.
package hsf_pkg;

  localparam int unsigned NameCapacity = 16;
  localparam int unsigned NameCntW     = $clog2(NameCapacity);

  localparam logic [7:0]  ChHash  = 8'h23;
  localparam logic [7:0]  ChComma = 8'h2C;
  localparam logic [7:0]  ChStar  = 8'h2A;
  localparam logic [7:0]  ChCr    = 8'h0D;
  localparam logic [7:0]  ChLf    = 8'h0A;
  localparam logic [7:0]  ChM     = 8'h4D;
  localparam logic [7:0]  CaseBit = 8'h20;

  // index 0 holds 'M'
  localparam logic [3:0][7:0] ModeWord = {8'h45, 8'h44, 8'h4F, 8'h4D};

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [15:0] MaxLenReset = 16'd1024;
  localparam logic [16:0] LenOverhead = 17'd3;

  typedef enum logic [6:0] {
    PhIdle    = 7'b000_0001,
    PhName    = 7'b000_0010,
    PhPayload = 7'b000_0100,
    PhDigits  = 7'b000_1000,
    PhTerm    = 7'b001_0000,
    PhWaitLf  = 7'b010_0000,
    PhWaitCr  = 7'b100_0000
  } phase_e;

  typedef enum logic [2:0] {
    StNone     = 3'd0,
    StGood     = 3'd1,
    StBadXor   = 3'd2,
    StBadCrc   = 3'd3,
    StTooLong  = 3'd4,
    StBadName  = 3'd5,
    StNameLong = 3'd6,
    StBadHex   = 3'd7
  } status_e;

  typedef struct packed {
    logic    done;
    status_e status;
    logic    in_sentence;
    logic    short_check;
  } hsf_result_t;

  // one byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

### sv/hash_sentence_framer.sv
// Top level of the hash sentence framer: input register, framing core, result register.
// Depends on hsf_pkg and hsf_frame.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid_i/s_axis_tready_o | tdata: received byte
//  m_axis    | out       | m_axis_tvalid_o/m_axis_tready_i | tdata status, tlast done,
//            |           |                                 | tuser in-sentence/short check
//  cfg       | in        | cfg_valid_i/cfg_ready_o         | max sentence length (16 bit)
//
// One result beat per input beat. A byte is registered on acceptance; the framing
// core (CRC-32 byte step, hex decode, compares) then updates its state and loads
// the result register once that is empty or being drained: one beat per cycle
// while m_axis does not stall. The input and result registers are the only buffering;
// a stalled m_axis holds both, so s_axis_tready_o drops only when both are full.
// Reset clears all framing state; max sentence length returns to 1024.
// cfg is always ready; write it only while no beat is in flight.
module hash_sentence_framer
  import hsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [2:0] status, [7:3] zero
  output logic        m_axis_tlast_o,   // sentence_done
  output logic [1:0]  m_axis_tuser_o,   // [0] in_sentence, [1] uses_short_check
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_wdata_i       // max_sentence_length
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  hsf_result_t out_q;
  hsf_result_t step_res;
  logic [15:0] max_len_q;
  logic        advance;
  logic        step;
  logic        s_fire;

  // core may run whenever the result register is empty or being drained
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  hsf_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_len_q   <= MaxLenReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (step) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.status};
  assign m_axis_tlast_o  = out_q.done;
  assign m_axis_tuser_o  = {out_q.short_check, out_q.in_sentence};

endmodule

### sv/hsf_frame.sv
// Framing state and the per-beat next-state / status logic.
// Depends on hsf_pkg.
module hsf_frame
  import hsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] max_len_i,
  output hsf_result_t result_o
);

  phase_e               phase_q, phase_d;
  logic [7:0]           xor_q, xor_d;
  logic [31:0]          crc_q, crc_d;
  logic [31:0]          rchk_q, rchk_d;
  logic [3:0]           digits_q, digits_d;
  logic [NameCntW-1:0]  name_cnt_q, name_cnt_d;
  logic [2:0]           prog_q, prog_d;
  logic                 short_q, short_d;
  logic [15:0]          len_q, len_d;

  logic [15:0] len_sat;
  logic [31:0] crc_fed;
  logic [4:0]  hex;
  logic [7:0]  up;
  logic        name_ok;
  logic        done;
  logic        term_hit;
  status_e     status;
  status_e     verdict;

  assign len_sat = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
  assign crc_fed = crc_byte(crc_q, byte_i);
  assign hex     = hex_nibble(byte_i);
  assign up      = byte_i & ~CaseBit;
  assign name_ok = (up >= 8'h41 && up <= 8'h5A) || (byte_i >= 8'h30 && byte_i <= 8'h39);

  // end-of-sentence verdict from the state as it stands
  always_comb begin
    if (short_q) begin
      verdict = (rchk_q[7:0] == xor_q) ? StGood : StBadXor;
    end else begin
      verdict = (rchk_q == crc_q) ? StGood : StBadCrc;
    end
    if (verdict == StGood && ({1'b0, len_q} + LenOverhead > {1'b0, max_len_i})) begin
      verdict = StTooLong;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    xor_d      = xor_q;
    crc_d      = crc_q;
    rchk_d     = rchk_q;
    digits_d   = digits_q;
    name_cnt_d = name_cnt_q;
    prog_d     = prog_q;
    short_d    = short_q;
    len_d      = len_q;
    done       = 1'b0;
    term_hit   = 1'b0;
    status     = StNone;

    unique case (phase_q)
      PhName: begin
        len_d = len_sat;
        xor_d = xor_q ^ byte_i;
        crc_d = crc_fed;
        if (byte_i != ChComma || name_cnt_q == '0) begin
          if (!name_ok) begin
            done   = 1'b1;
            status = StBadName;
          end else if (name_cnt_q >= NameCntW'(NameCapacity - 1)) begin
            done   = 1'b1;
            status = StNameLong;
          end else begin
            name_cnt_d = name_cnt_q + NameCntW'(1);
            if (prog_q < 3'd4) begin
              if (byte_i == ModeWord[prog_q[1:0]]) begin
                prog_d = prog_q + 3'd1;
              end else begin
                prog_d = (byte_i == ChM) ? 3'd1 : 3'd0;
              end
            end
          end
        end else begin
          short_d = (prog_q >= 3'd4);
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        len_d = len_sat;
        if (byte_i == ChStar) begin
          digits_d = short_q ? 4'd2 : 4'd8;
          phase_d  = PhDigits;
        end else begin
          xor_d = xor_q ^ byte_i;
          crc_d = crc_fed;
          if ({1'b0, len_sat} + LenOverhead > {1'b0, max_len_i}) begin
            done   = 1'b1;
            status = StTooLong;
          end
        end
      end
      PhDigits: begin
        len_d    = len_sat;
        digits_d = digits_q - 4'd1;
        if (!hex[4]) begin
          done   = 1'b1;
          status = StBadHex;
        end else begin
          rchk_d = {rchk_q[27:0], hex[3:0]};
          if (digits_q == 4'd1) begin
            phase_d = PhTerm;
          end
        end
      end
      PhTerm: begin
        if (byte_i == ChCr) begin
          phase_d = PhWaitLf;
        end else if (byte_i == ChLf) begin
          phase_d = PhWaitCr;
        end else begin
          done   = 1'b1;
          status = verdict;
        end
      end
      PhWaitLf, PhWaitCr: begin
        done     = 1'b1;
        status   = verdict;
        // matching second terminator closes cleanly, no re-examination
        term_hit = (phase_q == PhWaitLf) ? (byte_i == ChLf) : (byte_i == ChCr);
        if (term_hit) begin
          phase_d = PhIdle;
        end
      end
      default: begin
        // idle, handled by the restart below
      end
    endcase

    // idle bytes and aborting bytes are looked at as a possible '#'
    if ((phase_q == PhIdle) || (done && !term_hit)) begin
      if (byte_i == ChHash) begin
        phase_d    = PhName;
        xor_d      = '0;
        crc_d      = '0;
        rchk_d     = '0;
        digits_d   = '0;
        name_cnt_d = '0;
        prog_d     = '0;
        short_d    = 1'b0;
        len_d      = 16'd1;
      end else begin
        phase_d = PhIdle;
      end
    end
  end

  assign result_o.done        = done;
  assign result_o.status      = status;
  assign result_o.in_sentence = (phase_d != PhIdle);
  assign result_o.short_check = done ? short_q : short_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      xor_q      <= '0;
      crc_q      <= '0;
      rchk_q     <= '0;
      digits_q   <= '0;
      name_cnt_q <= '0;
      prog_q     <= '0;
      short_q    <= 1'b0;
      len_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      xor_q      <= xor_d;
      crc_q      <= crc_d;
      rchk_q     <= rchk_d;
      digits_q   <= digits_d;
      name_cnt_q <= name_cnt_d;
      prog_q     <= prog_d;
      short_q    <= short_d;
      len_q      <= len_d;
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for hash_sentence_framer: streams framed and broken
// '#'-sentences, predicts each status beat in-line and checks it field by field.
// Depends on hsf_pkg and the framer RTL only.
`timescale 1ns / 100ps

module testbench;
  import hsf_pkg::*;

  localparam int QuietLimit = 4000;   // cycles without any beat before giving up
  localparam int ChunkBytes = 120;

  typedef enum int {EndCrLf, EndLfCr, EndCr, EndLf, EndCrCr, EndLfLf, EndBare} ending_e;
  typedef enum int {FlawNone, FlawCheck, FlawHex, FlawCut} flaw_e;

  // ---------------------------------------------------------------- DUT ports
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;    // [7:0] data_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;          // [2:0] status, [7:3] zero
  logic        m_axis_tlast_o;          // sentence_done
  logic [1:0]  m_axis_tuser_o;          // [0] in_sentence, [1] uses_short_check
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_wdata_i     = '0;    // max_sentence_length

  hash_sentence_framer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------- framer prediction
  // Own copy of the framing state, advanced once per accepted input beat.
  phase_e      fr_phase       = PhIdle;
  logic [7:0]  fr_xor         = '0;
  logic [31:0] fr_crc         = '0;
  logic [31:0] fr_rx_check    = '0;
  logic [3:0]  fr_digits_left = '0;
  logic [4:0]  fr_name_len    = '0;
  logic [2:0]  fr_mode_prog   = '0;
  logic        fr_short       = 1'b0;
  logic [15:0] fr_length      = '0;
  logic [15:0] max_len        = MaxLenReset;

  // reflected CRC-32, one data bit per iteration
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c;
    for (int k = 0; k < 8; k++) v = (v >> 1) ^ ((v[0] ^ b[k]) ? CrcPoly : 32'd0);
    return v;
  endfunction

  // {valid, value}; 'A'/'a' carry 1 in the low nibble, hence the +9
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, b[3:0]};
    if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) return {1'b1, b[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    logic [7:0] up;
    up = b & ~CaseBit;
    return (up >= "A" && up <= "Z") || (b >= "0" && b <= "9");
  endfunction

  function automatic logic over_limit();
    return ({1'b0, fr_length} + LenOverhead) > {1'b0, max_len};
  endfunction

  function automatic void bump_length();
    if (fr_length != 16'hFFFF) fr_length++;
  endfunction

  // check comparison first, length only spoils an otherwise good sentence
  function automatic status_e verdict();
    status_e v;
    if (fr_short) v = (fr_rx_check[7:0] == fr_xor) ? StGood : StBadXor;
    else          v = (fr_rx_check == fr_crc) ? StGood : StBadCrc;
    if (v == StGood && over_limit()) v = StTooLong;
    return v;
  endfunction

  // a byte that ends or aborts a sentence may itself open the next one
  function automatic void reopen(input logic [7:0] b);
    if (b == ChHash) begin
      fr_phase       = PhName;
      fr_xor         = '0;
      fr_crc         = '0;
      fr_rx_check    = '0;
      fr_digits_left = '0;
      fr_name_len    = '0;
      fr_mode_prog   = '0;
      fr_short       = 1'b0;
      fr_length      = 16'd1;
    end else begin
      fr_phase = PhIdle;
    end
  endfunction

  function automatic hsf_result_t frame_byte(input logic [7:0] b);
    hsf_result_t r;
    logic        done;
    logic        ended_short;
    status_e     st;
    logic [4:0]  hx;
    done        = 1'b0;
    st          = StNone;
    ended_short = fr_short;
    case (fr_phase)
      PhName: begin
        bump_length();
        fr_xor ^= b;
        fr_crc = crc_step(fr_crc, b);
        if (b != ChComma || fr_name_len == 0) begin
          if (!is_alnum(b)) begin
            done = 1'b1;
            st   = StBadName;
          end else if (fr_name_len >= NameCapacity - 1) begin
            done = 1'b1;
            st   = StNameLong;
          end else begin
            fr_name_len++;
            // "MODE" tracker: a mismatching 'M' restarts the match at one
            if (fr_mode_prog < 3'd4)
              fr_mode_prog = (b == ModeWord[fr_mode_prog[1:0]]) ? fr_mode_prog + 3'd1 :
                             ((b == ChM) ? 3'd1 : 3'd0);
          end
        end else begin
          fr_short = (fr_mode_prog >= 3'd4);
          fr_phase = PhPayload;
        end
      end
      PhPayload: begin
        bump_length();
        if (b == ChStar) begin
          fr_digits_left = fr_short ? 4'd2 : 4'd8;
          fr_phase       = PhDigits;
        end else begin
          fr_xor ^= b;
          fr_crc = crc_step(fr_crc, b);
          if (over_limit()) begin
            done = 1'b1;
            st   = StTooLong;
          end
        end
      end
      PhDigits: begin
        bump_length();
        fr_digits_left = fr_digits_left - 4'd1;
        hx = hex_digit(b);
        if (!hx[4]) begin
          done = 1'b1;
          st   = StBadHex;
        end else begin
          fr_rx_check = {fr_rx_check[27:0], hx[3:0]};
          if (fr_digits_left == 0) fr_phase = PhTerm;
        end
      end
      PhTerm: begin
        if (b == ChCr) begin
          fr_phase = PhWaitLf;
        end else if (b == ChLf) begin
          fr_phase = PhWaitCr;
        end else begin
          done = 1'b1;
          st   = verdict();
        end
      end
      PhWaitLf, PhWaitCr: begin
        // the partner terminator closes quietly; anything else is reopened
        // below, and a CR or LF can never open a sentence
        done = 1'b1;
        st   = verdict();
        if (b == ((fr_phase == PhWaitLf) ? ChLf : ChCr)) fr_phase = PhIdle;
      end
      default: begin
        reopen(b);
      end
    endcase
    if (done) reopen(b);
    r.done        = done;
    r.status      = st;
    r.in_sentence = (fr_phase != PhIdle);
    r.short_check = done ? ended_short : fr_short;
    return r;
  endfunction

  // ----------------------------------------------------------- traffic state
  logic [7:0]  bytes_to_send [$];
  hsf_result_t status_due [$];
  logic [7:0]  body [$];              // name, comma and payload of the next sentence
  int unsigned bytes_queued = 0;
  int unsigned beats_out    = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  logic        byte_taken   = 1'b0;
  logic        calm         = 1'b0;   // stretch with no idling on either side
  logic        send_valid   = 1'b0;
  logic [7:0]  send_byte    = '0;
  int unsigned send_gap     = 0;
  int unsigned sink_stall   = 0;

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t: beat %0d %s mismatch: got %0h, want %0h",
             $time, beats_out, what, got, want);
  endtask

  task automatic check_beat();
    hsf_result_t want;
    beats_out++;
    if (status_due.size() == 0) begin
      flag_mismatch("unexpected beat", {m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o}, 0);
      return;
    end
    want = status_due.pop_front();
    if (m_axis_tlast_o !== want.done)
      flag_mismatch("sentence_done", m_axis_tlast_o, want.done);
    if (m_axis_tdata_o !== {5'd0, want.status})
      flag_mismatch("status", m_axis_tdata_o, want.status);
    if (m_axis_tuser_o[0] !== want.in_sentence)
      flag_mismatch("in_sentence", m_axis_tuser_o[0], want.in_sentence);
    if (m_axis_tuser_o[1] !== want.short_check)
      flag_mismatch("uses_short_check", m_axis_tuser_o[1], want.short_check);
  endtask

  // Sampling at the rising edge: predict on every input beat, check every
  // output beat, and keep the watchdog count of cycles with no beat at all.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        status_due.push_back(frame_byte(s_axis_tdata_i));
        byte_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) check_beat();
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Byte driver: holds tvalid until the beat is taken, then an idle gap or
  // straight on with the next byte (valid stays high, one assignment).
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        send_valid = 1'b0;
        send_gap   = pick_gap();
        if ($urandom_range(59) == 0) calm = ~calm;
      end
      if (!send_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (bytes_to_send.size() != 0) begin
          send_byte  = bytes_to_send.pop_front();
          send_valid = 1'b1;
        end
      end
      s_axis_tvalid_i <= send_valid;
      s_axis_tdata_i  <= send_byte;
    end
  end

  // Result sink: back-pressure independent of tvalid, same gap profile.
  always @(negedge clk_i) begin
    if (sink_stall != 0) begin
      sink_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // -------------------------------------------------------- stimulus builders
  task automatic stream_byte(input logic [7:0] b);
    bytes_to_send.push_back(b);
    bytes_queued++;
  endtask

  task automatic load_body(input string s);
    body.delete();
    for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
  endtask

  function automatic logic [7:0] alnum();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  // either case for the letters, the framer takes both
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return (($urandom_range(1) != 0) ? "a" : "A") + n - 8'd10;
  endfunction

  // '#', body, '*', check digits and terminator; the check kind follows the
  // name exactly as the framer will judge it, so unflawed sentences pass
  task automatic emit_sentence(input int unsigned name_len, input flaw_e flaw,
                               input ending_e ending);
    logic [7:0]  frame [$];
    logic [31:0] sum_crc;
    logic [31:0] chk;
    logic [7:0]  sum_xor;
    logic [7:0]  c;
    logic [4:0]  hx;
    logic [2:0]  prog;
    int unsigned ndig;
    int unsigned keep;
    int          d;
    sum_xor = '0;
    sum_crc = '0;
    prog    = '0;
    foreach (body[i]) begin
      sum_xor ^= body[i];
      sum_crc = crc_step(sum_crc, body[i]);
      if (i < name_len && prog < 3'd4)
        prog = (body[i] == ModeWord[prog[1:0]]) ? prog + 3'd1 : ((body[i] == ChM) ? 3'd1 : 3'd0);
    end
    ndig = (prog == 3'd4) ? 2 : 8;
    chk  = (prog == 3'd4) ? {24'd0, sum_xor} : sum_crc;
    if (flaw == FlawCheck) chk[$urandom_range(ndig * 4 - 1)] ^= 1'b1;
    frame.push_back(ChHash);
    foreach (body[i]) frame.push_back(body[i]);
    frame.push_back(ChStar);
    for (d = int'(ndig) - 1; d >= 0; d--) frame.push_back(hex_char(chk[d * 4 +: 4]));
    if (flaw == FlawHex) begin
      do begin
        c  = 8'($urandom_range(255));
        hx = hex_digit(c);
      end while (hx[4]);
      frame[frame.size() - 1 - $urandom_range(ndig - 1)] = c;
    end
    // lone CR/LF and bare endings leave the next byte to close the sentence
    case (ending)
      EndCrLf: begin
        frame.push_back(ChCr);
        frame.push_back(ChLf);
      end
      EndLfCr: begin
        frame.push_back(ChLf);
        frame.push_back(ChCr);
      end
      EndCr:   frame.push_back(ChCr);
      EndLf:   frame.push_back(ChLf);
      EndCrCr: begin
        frame.push_back(ChCr);
        frame.push_back(ChCr);
      end
      EndLfLf: begin
        frame.push_back(ChLf);
        frame.push_back(ChLf);
      end
      default: ;
    endcase
    keep = (flaw == FlawCut) ? $urandom_range(frame.size() - 1, 1) : frame.size();
    for (d = 0; d < int'(keep); d++) stream_byte(frame[d]);
  endtask

  // Mostly well-formed sentences with random content; the rest carry a bad
  // name character, an empty or oversized name, a wrong check, a bad digit,
  // a cut-off tail or stray noise bytes. Payloads are sometimes sized right
  // at the length limit so both the payload abort and the final check hit.
  task automatic random_sentence();
    int unsigned nl;
    int unsigned pl;
    int unsigned pick;
    int unsigned pos;
    int unsigned k;
    int          room;
    flaw_e       flaw;
    logic [7:0]  c;
    body.delete();
    pick = $urandom_range(99);
    nl = (pick < 85) ? $urandom_range(8, 1) :
         (pick < 95) ? $urandom_range(15, 9) : $urandom_range(18, 16);
    for (k = 0; k < nl; k++) body.push_back(alnum());
    if (nl >= 4 && $urandom_range(1) == 0) begin
      pos = $urandom_range(nl - 4);
      for (k = 0; k < 4; k++) body[pos + k] = ModeWord[k];
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      do c = 8'($urandom_range(255)); while (is_alnum(c) || c == ChComma);
      body[$urandom_range(nl - 1)] = c;
    end else if (pick < 7) begin
      body.delete();
      nl = 0;
    end
    body.push_back(ChComma);
    room = int'(max_len) - int'(nl) - 5;
    if (max_len <= 16'd200 && $urandom_range(4) == 0)
      pl = (room > 2) ? room - 2 + $urandom_range(4) : $urandom_range(4);
    else
      pl = $urandom_range(12);
    for (k = 0; k < pl; k++) begin
      do c = 8'($urandom_range(255)); while (c == ChStar);
      body.push_back(c);
    end
    pick = $urandom_range(99);
    flaw = (pick < 72) ? FlawNone : (pick < 82) ? FlawCheck : (pick < 90) ? FlawHex : FlawCut;
    emit_sentence(nl, flaw, ending_e'($urandom_range(6)));
    if ($urandom_range(6) == 0)
      repeat ($urandom_range(3, 1)) stream_byte(8'($urandom_range(255)));
  endtask

  // hold the sender until every byte is out and every status beat is back
  task automatic wait_quiet();
    while (bytes_to_send.size() != 0 || s_axis_tvalid_i || status_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // two chunks per setting with a full drain between them
  task automatic run_phase();
    int unsigned mark;
    repeat (2) begin
      mark = bytes_queued;
      while (bytes_queued - mark < ChunkBytes) random_sentence();
      wait_quiet();
    end
  endtask

  task automatic set_max_len(input logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ------------------------------------------------------------- test flow
  initial begin : stimulus
    logic [15:0] limits [6];
    limits    = '{16'd4, 16'hFFFF, 16'd16, 16'd40, 16'd0, MaxLenReset};
    limits[4] = 16'($urandom_range(120, 5));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: xor check with CR LF, crc check over an empty payload with
    // LF CR, an empty name, then the byte extremes while idle
    load_body("MODE,Ab");
    emit_sentence(4, FlawNone, EndCrLf);
    load_body("Z9,");
    emit_sentence(2, FlawNone, EndLfCr);
    stream_byte(ChHash);
    stream_byte(ChComma);
    stream_byte(8'h00);
    stream_byte(8'hFF);

    // reset value of the limit first, then every other setting
    run_phase();
    foreach (limits[p]) begin
      set_max_len(limits[p]);
      run_phase();
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0) flag_mismatch("missing beats", status_due.size(), 0);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/hsf_pkg.sv
sv/hsf_frame.sv
sv/hash_sentence_framer.sv
tb/testbench.sv
